// ===== hw/rtl/mis_pkg.sv =====
// ----------------------------------------------------------------------------
// mis_pkg
// Shared types and constants for the merged interval set insert core.
// ----------------------------------------------------------------------------
package mis_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int IDX_W           = 6;
  localparam int COUNT_OUT_W     = 7;
  localparam int STATUS_W        = 2;
  // cells per first-level group of the select tree
  localparam int GROUP_SIZE      = 8;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_BAD   = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_SEL,
    FSM_MRG,
    FSM_SHIFT,
    FSM_OUT
  } fsm_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_GROW,
    CELL_MERGE,
    CELL_SHL
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/merged_interval_set_insert_core.sv =====
// ----------------------------------------------------------------------------
// merged_interval_set_insert_core
// Sorted table of disjoint intervals in a row of cells; inserts absorb every
// overlapping or touching entry, reads return one entry by sorted position.
// ----------------------------------------------------------------------------
// Flow: a read, a rejected insert or an insert absorbing no entry passes compare,
// select tree, merge and output register before its result beat is valid. An
// insert absorbing entries also passes the shift state: neighbor moves close the
// gap, one per absorbed entry past the first, and one more step sees it closed.
// Throughput: one item in flight; the next input waits until the result is registered, later under stall.
// Reset: synchronous, active low; clears the count, so the table is empty.
// ----------------------------------------------------------------------------
module merged_interval_set_insert_core #(
  parameter int TABLE_DEPTH = mis_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_WIDTH = mis_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [COORD_WIDTH-1:0]           in_new_begin,
  input  logic [COORD_WIDTH-1:0]           in_new_end,
  input  logic [mis_pkg::IDX_W-1:0]        in_read_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mis_pkg::STATUS_W-1:0]     out_status,
  output logic [mis_pkg::COUNT_OUT_W-1:0]  out_entry_count,
  output logic [COORD_WIDTH-1:0]           out_entry_begin,
  output logic [COORD_WIDTH-1:0]           out_entry_end
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int NGRP  = (TABLE_DEPTH + mis_pkg::GROUP_SIZE - 1) / mis_pkg::GROUP_SIZE;

  mis_pkg::fsm_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic                        mode_r;
  logic [COORD_WIDTH-1:0]      nb_r;
  logic [COORD_WIDTH-1:0]      ne_r;
  logic [mis_pkg::IDX_W-1:0]   idx_r;

  mis_pkg::status_t       res_status_r, res_status_nxt;
  logic [COORD_WIDTH-1:0] res_lo_r, res_lo_nxt;
  logic [COORD_WIDTH-1:0] res_hi_r, res_hi_nxt;
  logic [COORD_WIDTH-1:0] m_lo, m_hi;

  mis_pkg::status_t            out_status_r;
  logic [mis_pkg::COUNT_OUT_W-1:0] out_count_r;
  logic [COORD_WIDTH-1:0]      out_lo_r;
  logic [COORD_WIDTH-1:0]      out_hi_r;
  logic [mis_pkg::COUNT_OUT_W-1:0] count_out;

  mis_pkg::cell_ctl_t ctl;

  logic [COORD_WIDTH-1:0] cell_lo   [TABLE_DEPTH];
  logic [COORD_WIDTH-1:0] cell_hi   [TABLE_DEPTH];
  logic                   cell_hit  [TABLE_DEPTH];
  logic                   cell_left [TABLE_DEPTH];
  logic [COORD_WIDTH-1:0] sel_lo    [TABLE_DEPTH];
  logic [COORD_WIDTH-1:0] sel_hi    [TABLE_DEPTH];
  logic                   reg_hit   [TABLE_DEPTH];

  logic [COORD_WIDTH-1:0] grp_lo_r [NGRP];
  logic [COORD_WIDTH-1:0] grp_hi_r [NGRP];
  logic [COORD_WIDTH-1:0] grp_lo_nxt [NGRP];
  logic [COORD_WIDTH-1:0] grp_hi_nxt [NGRP];
  logic [COORD_WIDTH-1:0] tree_lo, tree_hi;
  logic                   any_hit_r, any_hit;
  logic                   region_any;
  logic                   bad;
  logic                   full;

  // ---- cell row ----
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                   left_prev;
    logic                   hit_next;
    logic [COORD_WIDTH-1:0] prev_lo, prev_hi, next_lo, next_hi;

    if (i == 0) begin : g_first
      assign left_prev = 1'b1;
      assign prev_lo   = '0;
      assign prev_hi   = '0;
    end else begin : g_mid_l
      assign left_prev = cell_left[i-1];
      assign prev_lo   = cell_lo[i-1];
      assign prev_hi   = cell_hi[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign hit_next = 1'b0;
      assign next_lo  = '0;
      assign next_hi  = '0;
    end else begin : g_mid_r
      assign hit_next = cell_hit[i+1];
      assign next_lo  = cell_lo[i+1];
      assign next_hi  = cell_hi[i+1];
    end

    mis_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .CNT_W       (CNT_W),
      .INDEX       (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .count      (count_r),
      .q_lo       (nb_r),
      .q_hi       (ne_r),
      .m_lo       (m_lo),
      .m_hi       (m_hi),
      .rd_idx     (idx_r),
      .left_prev  (left_prev),
      .hit_next   (hit_next),
      .prev_lo    (prev_lo),
      .prev_hi    (prev_hi),
      .next_lo    (next_lo),
      .next_hi    (next_hi),
      .lo_o       (cell_lo[i]),
      .hi_o       (cell_hi[i]),
      .hit_o      (cell_hit[i]),
      .left_o     (cell_left[i]),
      .sel_lo     (sel_lo[i]),
      .sel_hi     (sel_hi[i]),
      .region_hit (reg_hit[i])
    );
  end

  // ---- select tree: one-hot picks, OR'd in registered groups ----
  always_comb begin
    any_hit    = 1'b0;
    region_any = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      any_hit    = any_hit | cell_hit[i];
      region_any = region_any | reg_hit[i];
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_lo_nxt[g] = '0;
      grp_hi_nxt[g] = '0;
      for (int j = 0; j < mis_pkg::GROUP_SIZE; j++) begin
        if (g * mis_pkg::GROUP_SIZE + j < TABLE_DEPTH) begin
          grp_lo_nxt[g] = grp_lo_nxt[g] | sel_lo[g * mis_pkg::GROUP_SIZE + j];
          grp_hi_nxt[g] = grp_hi_nxt[g] | sel_hi[g * mis_pkg::GROUP_SIZE + j];
        end
      end
    end
    tree_lo = '0;
    tree_hi = '0;
    for (int g = 0; g < NGRP; g++) begin
      tree_lo = tree_lo | grp_lo_r[g];
      tree_hi = tree_hi | grp_hi_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mis_pkg::FSM_SEL) begin
      grp_lo_r  <= grp_lo_nxt;
      grp_hi_r  <= grp_hi_nxt;
      any_hit_r <= any_hit;
    end
  end

  // ---- merge arithmetic ----
  assign bad  = $signed(ne_r) < $signed(nb_r);
  assign full = !any_hit_r && (count_r >= CNT_W'(TABLE_DEPTH));
  assign m_lo = (any_hit_r && ($signed(tree_lo) < $signed(nb_r))) ? tree_lo : nb_r;
  assign m_hi = (any_hit_r && ($signed(tree_hi) > $signed(ne_r))) ? tree_hi : ne_r;

  // ---- control ----
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    res_status_nxt = res_status_r;
    res_lo_nxt     = res_lo_r;
    res_hi_nxt     = res_hi_r;
    ctl.op         = mis_pkg::CELL_HOLD;
    ctl.rd         = mode_r;
    in_ready       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mis_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = mis_pkg::FSM_CMP;
        end
      end
      mis_pkg::FSM_CMP: begin
        ctl.op    = mis_pkg::CELL_CMP;
        state_nxt = mis_pkg::FSM_SEL;
      end
      mis_pkg::FSM_SEL: begin
        state_nxt = mis_pkg::FSM_MRG;
      end
      mis_pkg::FSM_MRG: begin
        state_nxt = mis_pkg::FSM_OUT;
        if (mode_r) begin
          if (32'(idx_r) >= 32'(count_r)) begin
            res_status_nxt = mis_pkg::STS_RANGE;
            res_lo_nxt     = '0;
            res_hi_nxt     = '0;
          end else begin
            res_status_nxt = mis_pkg::STS_OK;
            res_lo_nxt     = tree_lo;
            res_hi_nxt     = tree_hi;
          end
        end else if (bad) begin
          res_status_nxt = mis_pkg::STS_BAD;
          res_lo_nxt     = '0;
          res_hi_nxt     = '0;
        end else if (full) begin
          res_status_nxt = mis_pkg::STS_FULL;
          res_lo_nxt     = '0;
          res_hi_nxt     = '0;
        end else begin
          res_status_nxt = mis_pkg::STS_OK;
          res_lo_nxt     = m_lo;
          res_hi_nxt     = m_hi;
          if (any_hit_r) begin
            ctl.op    = mis_pkg::CELL_MERGE;
            state_nxt = mis_pkg::FSM_SHIFT;
          end else begin
            ctl.op    = mis_pkg::CELL_GROW;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      mis_pkg::FSM_SHIFT: begin
        // each move drops one more absorbed entry right of the merged slot
        if (region_any) begin
          ctl.op    = mis_pkg::CELL_SHL;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          state_nxt = mis_pkg::FSM_OUT;
        end
      end
      mis_pkg::FSM_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = mis_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = mis_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mis_pkg::FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      nb_r   <= in_new_begin;
      ne_r   <= in_new_end;
      idx_r  <= in_read_index;
    end
    res_status_r <= res_status_nxt;
    res_lo_r     <= res_lo_nxt;
    res_hi_r     <= res_hi_nxt;
    if (state_r == mis_pkg::FSM_OUT && (!out_valid_r || out_ready)) begin
      out_status_r <= res_status_r;
      out_count_r  <= count_out;
      out_lo_r     <= res_lo_r;
      out_hi_r     <= res_hi_r;
    end
  end

  if (CNT_W >= mis_pkg::COUNT_OUT_W) begin : g_cnt_trunc
    assign count_out = count_r[mis_pkg::COUNT_OUT_W-1:0];
  end else begin : g_cnt_ext
    assign count_out = {{(mis_pkg::COUNT_OUT_W - CNT_W){1'b0}}, count_r};
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_entry_begin = out_lo_r;
  assign out_entry_end   = out_hi_r;

endmodule

// ===== hw/rtl/mis_cell.sv =====
// ----------------------------------------------------------------------------
// mis_cell
// One table slot: holds an interval, compares it with the query, flags its
// position relative to the merged slot and moves data to or from neighbors.
// ----------------------------------------------------------------------------
module mis_cell #(
  parameter int COORD_WIDTH = mis_pkg::COORD_WIDTH_DEF,
  parameter int CNT_W       = 7,
  parameter int INDEX       = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mis_pkg::cell_ctl_t       ctl,
  input  logic [CNT_W-1:0]         count,
  input  logic [COORD_WIDTH-1:0]   q_lo,
  input  logic [COORD_WIDTH-1:0]   q_hi,
  input  logic [COORD_WIDTH-1:0]   m_lo,
  input  logic [COORD_WIDTH-1:0]   m_hi,
  input  logic [mis_pkg::IDX_W-1:0] rd_idx,
  input  logic                     left_prev,
  input  logic                     hit_next,
  input  logic [COORD_WIDTH-1:0]   prev_lo,
  input  logic [COORD_WIDTH-1:0]   prev_hi,
  input  logic [COORD_WIDTH-1:0]   next_lo,
  input  logic [COORD_WIDTH-1:0]   next_hi,
  output logic [COORD_WIDTH-1:0]   lo_o,
  output logic [COORD_WIDTH-1:0]   hi_o,
  output logic                     hit_o,
  output logic                     left_o,
  output logic [COORD_WIDTH-1:0]   sel_lo,
  output logic [COORD_WIDTH-1:0]   sel_hi,
  output logic                     region_hit
);

  logic [COORD_WIDTH-1:0] lo_r, lo_nxt;
  logic [COORD_WIDTH-1:0] hi_r, hi_nxt;
  logic                   hit_r, hit_nxt;
  logic                   left_r, left_nxt;
  logic                   occupied;
  logic                   hit_cmp;
  logic                   left_cmp;
  logic                   is_p;
  logic                   gt_p;
  logic                   rd_match;

  assign occupied = CNT_W'(INDEX) < count;
  assign hit_cmp  = occupied && ($signed(hi_r) >= $signed(q_lo)) &&
                    ($signed(q_hi) >= $signed(lo_r));
  assign left_cmp = occupied && ($signed(hi_r) < $signed(q_lo));

  // entries left of the merged slot form a prefix, so neighbor flags suffice
  assign is_p     = !left_r && left_prev;
  assign gt_p     = !left_r && !left_prev;
  assign rd_match = 32'(rd_idx) == 32'(INDEX);

  assign sel_lo     = (ctl.rd ? rd_match : (hit_r && is_p)) ? lo_r : '0;
  assign sel_hi     = (ctl.rd ? rd_match : (hit_r && !hit_next)) ? hi_r : '0;
  assign region_hit = hit_r && gt_p;

  assign lo_o   = lo_r;
  assign hi_o   = hi_r;
  assign hit_o  = hit_r;
  assign left_o = left_r;

  always_comb begin
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    hit_nxt  = hit_r;
    left_nxt = left_r;
    case (ctl.op)
      mis_pkg::CELL_CMP: begin
        hit_nxt  = hit_cmp;
        left_nxt = left_cmp;
      end
      mis_pkg::CELL_GROW: begin
        if (is_p) begin
          lo_nxt  = m_lo;
          hi_nxt  = m_hi;
          hit_nxt = 1'b0;
        end else if (gt_p) begin
          lo_nxt  = prev_lo;
          hi_nxt  = prev_hi;
          hit_nxt = 1'b0;
        end
      end
      mis_pkg::CELL_MERGE: begin
        if (is_p) begin
          lo_nxt  = m_lo;
          hi_nxt  = m_hi;
          hit_nxt = 1'b0;
        end
      end
      mis_pkg::CELL_SHL: begin
        if (gt_p) begin
          lo_nxt  = next_lo;
          hi_nxt  = next_hi;
          hit_nxt = hit_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      left_r <= 1'b0;
    end else begin
      hit_r  <= hit_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

endmodule

// ===== bench/tb_merged_interval_set_insert_core.sv =====
// ----------------------------------------------------------------------------
// tb_merged_interval_set_insert_core
// Drives insert and read beats into the interval set core under random idling
// on both channels and checks every result beat against an in-bench model of
// the sorted, merged interval table.
// ----------------------------------------------------------------------------
module tb_merged_interval_set_insert_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = mis_pkg::TABLE_DEPTH_DEF;
  localparam int CW           = mis_pkg::COORD_WIDTH_DEF;
  localparam int IDX_W        = mis_pkg::IDX_W;
  localparam int COUNT_OUT_W  = mis_pkg::COUNT_OUT_W;
  localparam int STATUS_W     = mis_pkg::STATUS_W;
  localparam int SLOTS        = 128;
  localparam int SLOT_PITCH   = 4;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_ITEMS   = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 150;
  localparam int STALL_LIMIT  = 4000;
  // worst case: the longest item, with a shift per absorbed entry, past an idle burst
  localparam int DRAIN_CYCLES = 5 + DEPTH + 12;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};

  typedef struct {
    logic             mode;
    coord_t           lo;
    coord_t           hi;
    logic [IDX_W-1:0] idx;
  } interval_op_t;

  typedef struct {
    mis_pkg::status_t       status;
    logic [COUNT_OUT_W-1:0] count;
    coord_t                 lo;
    coord_t                 hi;
  } interval_reply_t;

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   in_valid        = 1'b0;
  logic                   in_ready;
  logic                   in_mode         = MODE_INSERT;
  logic [CW-1:0]          in_new_begin    = '0;
  logic [CW-1:0]          in_new_end      = '0;
  logic [IDX_W-1:0]       in_read_index   = '0;
  logic                   out_valid;
  logic                   out_ready       = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  logic [CW-1:0]          out_entry_begin;
  logic [CW-1:0]          out_entry_end;

  // model of the table
  coord_t tbl_begin [DEPTH];
  coord_t tbl_end   [DEPTH];
  int     tbl_count = 0;

  interval_op_t    interval_ops[$];
  interval_reply_t interval_replies[$];
  interval_op_t    next_op;
  interval_reply_t want;

  logic in_fire = 1'b0;
  int   send_gap = 0, recv_gap = 0, hold_left = 0, idle_cycles = 0;
  bit   send_calm = 0, recv_calm = 0, hold_done = 0;
  int   accepted_items = 0, results_checked = 0, mismatches = 0, n_directed = 0;
  int   status_tally [4] = '{default: 0};
  int   peak_count = 0, widest_merge = 0;

  merged_interval_set_insert_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_new_begin    (in_new_begin),
    .in_new_end      (in_new_end),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_entry_begin (out_entry_begin),
    .out_entry_end   (out_entry_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one op to the model table and returns the reply it should produce.
  function automatic interval_reply_t interval_set_apply(interval_op_t op);
    interval_reply_t rep;
    coord_t          lo, hi;
    coord_t          nb [DEPTH];
    coord_t          ne [DEPTH];
    bit              hit [DEPTH];
    int              absorbed, j;
    bit              placed;
    rep.status = mis_pkg::STS_OK;
    rep.lo     = '0;
    rep.hi     = '0;
    lo         = op.lo;
    hi         = op.hi;
    absorbed   = 0;
    j          = 0;
    placed     = 0;
    if (op.mode == MODE_READ) begin
      if (int'(op.idx) >= tbl_count) begin
        rep.status = mis_pkg::STS_RANGE;
      end else begin
        rep.lo = tbl_begin[op.idx];
        rep.hi = tbl_end[op.idx];
      end
    end else if (op.hi < op.lo) begin
      rep.status = mis_pkg::STS_BAD;
    end else begin
      // inclusive bounds: touching entries merge too
      for (int i = 0; i < tbl_count; i++) begin
        hit[i] = (tbl_end[i] >= op.lo) && (op.hi >= tbl_begin[i]);
        if (hit[i]) begin
          absorbed++;
          if (tbl_begin[i] < lo) lo = tbl_begin[i];
          if (tbl_end[i] > hi) hi = tbl_end[i];
        end
      end
      if (absorbed == 0 && tbl_count >= DEPTH) begin
        rep.status = mis_pkg::STS_FULL;
      end else begin
        for (int i = 0; i < tbl_count; i++) begin
          if (!hit[i]) begin
            if (!placed && lo < tbl_begin[i]) begin
              nb[j] = lo;
              ne[j] = hi;
              j++;
              placed = 1;
            end
            nb[j] = tbl_begin[i];
            ne[j] = tbl_end[i];
            j++;
          end
        end
        if (!placed) begin
          nb[j] = lo;
          ne[j] = hi;
          j++;
        end
        for (int i = 0; i < j; i++) begin
          tbl_begin[i] = nb[i];
          tbl_end[i]   = ne[i];
        end
        tbl_count = j;
        rep.lo    = lo;
        rep.hi    = hi;
        if (absorbed > widest_merge) widest_merge = absorbed;
      end
    end
    rep.count = COUNT_OUT_W'(tbl_count);
    status_tally[rep.status]++;
    if (tbl_count > peak_count) peak_count = tbl_count;
    return rep;
  endfunction

  task automatic add_insert(coord_t lo, coord_t hi);
    interval_op_t op;
    op.mode = MODE_INSERT;
    op.lo   = lo;
    op.hi   = hi;
    op.idx  = IDX_W'($urandom);
    interval_ops = {interval_ops, op};
  endtask

  task automatic add_read(int idx);
    interval_op_t op;
    op.mode = MODE_READ;
    op.lo   = coord_t'($urandom);
    op.hi   = coord_t'($urandom);
    op.idx  = IDX_W'(idx);
    interval_ops = {interval_ops, op};
  endtask

  // sender: new beat at the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (interval_ops.size() == 0) begin
        in_valid <= 1'b0;
      end else if (interval_ops.size() > TAIL_ITEMS && !send_calm &&
                   $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else begin
        next_op = interval_ops.pop_front();
        in_valid      <= 1'b1;
        in_mode       <= next_op.mode;
        in_new_begin  <= next_op.lo;
        in_new_end    <= next_op.hi;
        in_read_index <= next_op.idx;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off to back up the core
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted_items >= HOLD_AFTER) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (interval_ops.size() > TAIL_ITEMS && !recv_calm &&
                 $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
    end
  end

  // rising edge: check result beats, model accepted input beats, watchdog
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (interval_replies.size() == 0) begin
        $error("result beat with no outstanding item");
        mismatches++;
      end else begin
        want = interval_replies.pop_front();
        results_checked++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
          mismatches++;
        end
        if (out_entry_begin !== want.lo) begin
          $error("entry_begin: expected %0d, got %0d", want.lo, $signed(out_entry_begin));
          mismatches++;
        end
        if (out_entry_end !== want.hi) begin
          $error("entry_end: expected %0d, got %0d", want.hi, $signed(out_entry_end));
          mismatches++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      interval_replies = {interval_replies, interval_set_apply(next_op)};
      accepted_items++;
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("stalled for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    longint base;
    int     n, step, offset, slot, span, kind;
    coord_t a, b, t;

    // directed: empty reads, bad intervals, extremes, touching, multi-absorb
    add_read(0);
    add_read(2**IDX_W - 1);
    add_insert(coord_t'(5), coord_t'(4));
    add_insert(COORD_MAX, COORD_MIN);
    add_insert(COORD_MIN, COORD_MIN);
    add_insert(COORD_MAX, COORD_MAX);
    add_insert(coord_t'(10), coord_t'(20));
    add_insert(coord_t'(20), coord_t'(30));
    add_insert(coord_t'(31), coord_t'(40));
    add_insert(coord_t'(50), coord_t'(60));
    add_insert(coord_t'(70), coord_t'(80));
    add_insert(coord_t'(0), coord_t'(75));
    add_read(0);
    add_read(1);
    add_read(2);
    add_read(3);
    add_insert(coord_t'(-1), coord_t'(-1));
    add_read(1);
    add_insert(COORD_MIN, COORD_MAX);
    add_read(0);
    add_insert(coord_t'(1), coord_t'(0));
    add_read(2**IDX_W - 1);
    n_directed = interval_ops.size();

    while (interval_ops.size() < n_directed + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // fill a region with mostly disjoint intervals, often past the table depth
        case ($urandom_range(0, 3))
          0: base = longint'(COORD_MIN);
          1: base = longint'(COORD_MAX) - SLOTS * SLOT_PITCH - 8;
          default: begin
            base = longint'(int'($urandom));
            if (base > longint'(COORD_MAX) - 1024) base -= 1024;
          end
        endcase
        n      = ($urandom_range(0, 1) == 1) ? $urandom_range(DEPTH + 4, DEPTH + 16)
                                             : $urandom_range(4, 40);
        step   = 2 * $urandom_range(0, SLOTS / 2 - 1) + 1;
        offset = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < n; k++) begin
          slot = (offset + k * step) % SLOTS;
          span = ($urandom_range(0, 9) == 0) ? SLOT_PITCH : $urandom_range(0, 2);
          add_insert(coord_t'(base + slot * SLOT_PITCH),
                     coord_t'(base + slot * SLOT_PITCH + span));
          if ($urandom_range(0, 7) == 0) add_read($urandom_range(0, 2**IDX_W - 1));
        end
        // sweep the region so the next fill starts from a low count
        if ($urandom_range(0, 3) != 0) begin
          span = $urandom_range(0, 4);
          offset = $urandom_range(0, 2);
          add_insert(coord_t'(base + offset), coord_t'(base + SLOTS * SLOT_PITCH - span));
        end
      end else if (kind <= 5) begin
        repeat ($urandom_range(1, 8)) add_read($urandom_range(0, 2**IDX_W - 1));
      end else if (kind == 6) begin
        add_insert(coord_t'($urandom), coord_t'($urandom));
      end else if (kind == 7) begin
        a = coord_t'($urandom);
        b = coord_t'($urandom);
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        add_insert(a, b);
      end else begin
        // short intervals around zero, overlapping each other often
        a = coord_t'(int'($urandom_range(0, 200)) - 100);
        span = $urandom_range(0, 20);
        add_insert(a, coord_t'(a + span));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (interval_ops.size() != 0 || in_valid) @(posedge clk);
    while (interval_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items (%0d directed), %0d results checked; peak table %0d, widest merge %0d",
             accepted_items, n_directed, results_checked, peak_count, widest_merge);
    $display("status seen: ok %0d, full %0d, bad interval %0d, index beyond count %0d",
             status_tally[mis_pkg::STS_OK], status_tally[mis_pkg::STS_FULL],
             status_tally[mis_pkg::STS_BAD], status_tally[mis_pkg::STS_RANGE]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mis_pkg.sv
hw/rtl/mis_cell.sv
hw/rtl/merged_interval_set_insert_core.sv
bench/tb_merged_interval_set_insert_core.sv
